// ===== design/mbgu_pkg.sv =====
// ---------------------------------------------------------------------------
// mbgu_pkg: shared definitions of the masked bilinear grid upsampler
// Default sizes, field widths, item codes and the back-end state type.
// ---------------------------------------------------------------------------
package mbgu_pkg;

    // Default grid size and subdivision factor.
    localparam int GRID_SIDE_DEF = 64;
    localparam int SUBDIV_DEF    = 4;

    // Fixed field widths.
    localparam int OPCODE_W = 2;
    localparam int COARSE_W = 6;
    localparam int FINE_W   = 8;
    localparam int POS_W    = 32;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;

    // Width of the epoch tag that marks an entry as present.
    localparam int EPOCH_W = 3;

    // Input operation codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    // Commands handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_MISS  = 2'd3
    } cmd_kind_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_SWEEP = 3'd0,
        BK_IDLE  = 3'd1,
        BK_MAC   = 3'd2,
        BK_PREP  = 3'd3,
        BK_DIV   = 3'd4,
        BK_OUT   = 3'd5
    } back_state_t;

endpackage

// ===== design/mbgu_fifo.sv =====
// ---------------------------------------------------------------------------
// mbgu_fifo: short command queue
// A small register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module mbgu_fifo import mbgu_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNTW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and count update with wrap at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== design/mbgu_front.sv =====
// ---------------------------------------------------------------------------
// mbgu_front: item intake and classification
// Accepts items, drops the ignored ones, maps coordinates to cell addresses
// and cell offsets in a two-stage pipeline, and pushes commands to the queue.
// ---------------------------------------------------------------------------
module mbgu_front import mbgu_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int SUBDIV    = SUBDIV_DEF,
    parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE),
    parameter int OW        = $clog2(SUBDIV + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       init_done,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OPCODE_W-1:0]        s_opcode,
    input  logic signed [COARSE_W-1:0] s_grid_col,
    input  logic signed [COARSE_W-1:0] s_grid_row,
    input  logic signed [POS_W-1:0]    s_load_px,
    input  logic signed [POS_W-1:0]    s_load_py,
    input  logic signed [POS_W-1:0]    s_load_pz,
    input  logic signed [FINE_W-1:0]   s_fine_col,
    input  logic signed [FINE_W-1:0]   s_fine_row,
    output logic                       q_valid,
    input  logic                       q_ready,
    output cmd_kind_t                  q_kind,
    output logic [AW-1:0]              q_addr,
    output logic [OW-1:0]              q_ox,
    output logic [OW-1:0]              q_oy,
    output logic [FINE_W-1:0]          q_col,
    output logic [FINE_W-1:0]          q_row,
    output logic [POS_W-1:0]           q_px,
    output logic [POS_W-1:0]           q_py,
    output logic [POS_W-1:0]           q_pz
);

    localparam int GB     = $clog2(GRID_SIDE);
    localparam int CW     = (GB + 2 > COARSE_W + 1) ? GB + 2 : COARSE_W + 1;
    localparam int HALF_G = GRID_SIDE / 2;
    localparam int HALF_F = GRID_SIDE * SUBDIV / 2;
    localparam int NX     = $clog2(HALF_F + 128);
    localparam int XW     = NX + 1;
    localparam int SH     = NX + 5;
    localparam int MW     = SH + 1;
    localparam longint MULT = (longint'(1) << SH) / SUBDIV + 1;
    localparam int PRW    = NX + MW;
    localparam int CQW    = (NX > GB + 1) ? NX : GB + 1;

    // Stage one: classified item.
    logic                 v1_reg;
    cmd_kind_t            kind1_reg;
    logic [AW-1:0]        addr1_reg;
    logic [NX-1:0]        x1_reg, y1_reg;
    logic [FINE_W-1:0]    col1_reg, row1_reg;
    logic [POS_W-1:0]     px1_reg, py1_reg, pz1_reg;

    // Stage two: reciprocal products.
    logic                 v2_reg;
    cmd_kind_t            kind2_reg;
    logic [AW-1:0]        addr2_reg;
    logic [NX-1:0]        x2_reg, y2_reg;
    logic [PRW-1:0]       prodx2_reg, prody2_reg;
    logic [FINE_W-1:0]    col2_reg, row2_reg;
    logic [POS_W-1:0]     px2_reg, py2_reg, pz2_reg;

    logic                 adv2, adv1, accept;
    logic signed [CW-1:0] gc, gr;
    logic                 load_ok;
    logic [AW-1:0]        load_addr;
    logic signed [XW-1:0] fx, fy;
    logic                 keep;
    cmd_kind_t            kind_in;
    logic [NX-1:0]        xq, yq;
    logic                 cell_ok;

    assign adv2    = !v2_reg || q_ready;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = init_done && adv1;
    assign accept  = s_valid && s_ready;

    // Coarse load address and range check.
    always_comb begin
        gc        = CW'(s_grid_col) + CW'(HALF_G);
        gr        = CW'(s_grid_row) + CW'(HALF_G);
        load_ok   = !gc[CW-1] && !gr[CW-1] &&
                    (gc < CW'(GRID_SIDE)) && (gr < CW'(GRID_SIDE));
        load_addr = AW'(gc[GB-1:0]) * AW'(GRID_SIDE) + AW'(gr[GB-1:0]);
    end

    // Fine coordinates shifted to the grid origin.
    assign fx = XW'(s_fine_col) + XW'(HALF_F);
    assign fy = XW'(s_fine_row) + XW'(HALF_F);

    // Item classification; reserved codes and outside loads are dropped.
    always_comb begin
        keep    = 1'b0;
        kind_in = CMD_CLEAR;
        case (s_opcode)
            OP_LOAD: begin
                keep    = load_ok;
                kind_in = CMD_LOAD;
            end
            OP_QUERY: begin
                keep    = 1'b1;
                kind_in = (fx[XW-1] || fy[XW-1]) ? CMD_MISS : CMD_QUERY;
            end
            OP_CLEAR: begin
                keep    = 1'b1;
                kind_in = CMD_CLEAR;
            end
            default: begin
                keep    = 1'b0;
                kind_in = CMD_CLEAR;
            end
        endcase
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= accept && keep;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            kind1_reg <= kind_in;
            addr1_reg <= load_addr;
            x1_reg    <= fx[NX-1:0];
            y1_reg    <= fy[NX-1:0];
            col1_reg  <= s_fine_col;
            row1_reg  <= s_fine_row;
            px1_reg   <= s_load_px;
            py1_reg   <= s_load_py;
            pz1_reg   <= s_load_pz;
        end
        if (adv2) begin
            kind2_reg  <= kind1_reg;
            addr2_reg  <= addr1_reg;
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            prodx2_reg <= PRW'(x1_reg) * PRW'(MULT);
            prody2_reg <= PRW'(y1_reg) * PRW'(MULT);
            col2_reg   <= col1_reg;
            row2_reg   <= row1_reg;
            px2_reg    <= px1_reg;
            py2_reg    <= py1_reg;
            pz2_reg    <= pz1_reg;
        end
    end

    // Cell index, offset in the cell and last-row and last-column check.
    always_comb begin
        xq      = NX'(prodx2_reg >> SH);
        yq      = NX'(prody2_reg >> SH);
        cell_ok = (CQW'(xq) < CQW'(GRID_SIDE - 1)) && (CQW'(yq) < CQW'(GRID_SIDE - 1));
        q_ox    = OW'(x2_reg - xq * NX'(SUBDIV));
        q_oy    = OW'(y2_reg - yq * NX'(SUBDIV));
        q_kind  = kind2_reg;
        q_addr  = addr2_reg;
        if (kind2_reg == CMD_QUERY) begin
            q_kind = cell_ok ? CMD_QUERY : CMD_MISS;
            q_addr = AW'(xq) * AW'(GRID_SIDE) + AW'(yq);
        end
    end

    assign q_valid = v2_reg;
    assign q_col   = col2_reg;
    assign q_row   = row2_reg;
    assign q_px    = px2_reg;
    assign q_py    = py2_reg;
    assign q_pz    = pz2_reg;

endmodule

// ===== design/mbgu_back.sv =====
// ---------------------------------------------------------------------------
// mbgu_back: point store and interpolation engine
// Holds the point memory with epoch tags, writes loads, handles clears,
// reads four corners per query, accumulates weighted sums and divides
// with rounding, then presents the result item.
// ---------------------------------------------------------------------------
module mbgu_back import mbgu_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int SUBDIV    = SUBDIV_DEF,
    parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE),
    parameter int OW        = $clog2(SUBDIV + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    output logic                     init_done,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  cmd_kind_t                q_kind,
    input  logic [AW-1:0]            q_addr,
    input  logic [OW-1:0]            q_ox,
    input  logic [OW-1:0]            q_oy,
    input  logic [FINE_W-1:0]        q_col,
    input  logic [FINE_W-1:0]        q_row,
    input  logic [POS_W-1:0]         q_px,
    input  logic [POS_W-1:0]         q_py,
    input  logic [POS_W-1:0]         q_pz,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_valid_res,
    output logic signed [FINE_W-1:0] m_echo_col,
    output logic signed [FINE_W-1:0] m_echo_row,
    output logic signed [POS_W-1:0]  m_out_px,
    output logic signed [POS_W-1:0]  m_out_py,
    output logic signed [POS_W-1:0]  m_out_pz
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int DIVISOR = SUBDIV * SUBDIV;
    localparam int HALF_D = DIVISOR / 2;
    localparam int WW     = $clog2(DIVISOR + 1);
    localparam int SUMW   = POS_W + 1 + WW;
    localparam int RW     = $clog2(DIVISOR) + 1;
    localparam int DC     = 16;
    localparam int NCH    = (SUMW + DC - 1) / DC;
    localparam int QDW    = NCH * DC;
    localparam int NW     = RW + DC;
    localparam int RS     = NW + RW;
    localparam int MULW   = RS - $clog2(DIVISOR) + 2;
    localparam longint RMULT = (longint'(1) << RS) / DIVISOR + 1;
    localparam int PW2    = NW + MULW;
    localparam int BW     = $clog2(2 * NCH);
    localparam int EW     = EPOCH_W;
    localparam int DW     = EW + 3 * POS_W;
    localparam int LANES  = 3;

    // Point memory: epoch tag over z, y, x.
    logic [DW-1:0]          mem [CELLS];
    logic [DW-1:0]          rd_data_reg;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [DW-1:0]          mem_wdata;

    back_state_t            state_reg, state_next;
    logic                   init_done_reg;
    logic [EW-1:0]          epoch_reg;
    logic [AW-1:0]          sweep_reg;
    logic [2:0]             phase_reg;
    logic [BW-1:0]          bit_reg;
    logic                   miss_reg;
    logic [AW-1:0]          base_reg;
    logic [WW-1:0]          w_reg [4];
    logic [FINE_W-1:0]      col_reg, row_reg;
    logic signed [SUMW-1:0] prod_reg [LANES];
    logic signed [SUMW-1:0] acc_reg [LANES];
    logic                   neg_reg [LANES];
    logic [QDW-1:0]         mag_reg [LANES];
    logic [RW-1:0]          rem_reg [LANES];
    logic [PW2-1:0]         rprod_reg [LANES];

    logic                   m_valid_reg, m_valid_res_reg;
    logic [FINE_W-1:0]      m_col_reg, m_row_reg;
    logic [POS_W-1:0]       m_pos_reg [LANES];

    logic                   pop, out_free;
    logic [OW:0]            sx, sy;
    logic [1:0]             corner;
    logic [NW-1:0]          num [LANES];
    logic [DC-1:0]          qc [LANES];
    logic [RW-1:0]          rem_nx [LANES];
    logic [POS_W-1:0]       quot [LANES];

    assign pop       = q_valid && q_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign init_done = init_done_reg;
    assign corner    = 2'(phase_reg - 3'd1);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_SWEEP: begin
                if (sweep_reg == AW'(CELLS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    case (q_kind)
                        CMD_QUERY: state_next = BK_MAC;
                        CMD_MISS:  state_next = BK_OUT;
                        CMD_CLEAR: state_next = (epoch_reg == '1) ? BK_SWEEP : BK_IDLE;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_MAC: begin
                if (phase_reg == 3'd5) begin
                    state_next = BK_PREP;
                end
            end
            BK_PREP: begin
                state_next = miss_reg ? BK_OUT : BK_DIV;
            end
            BK_DIV: begin
                if (bit_reg == BW'(2 * NCH - 1)) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_SWEEP;
            end
        endcase
    end

    // Memory control outputs.
    always_comb begin
        q_ready   = (state_reg == BK_IDLE);
        mem_we    = 1'b0;
        mem_waddr = q_addr;
        mem_wdata = {epoch_reg, q_pz, q_py, q_px};
        mem_re    = 1'b0;
        mem_raddr = base_reg + (phase_reg[0] ? AW'(GRID_SIDE) : '0)
                             + (phase_reg[1] ? AW'(1) : '0);
        case (state_reg)
            BK_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
            end
            BK_IDLE: begin
                mem_we = pop && (q_kind == CMD_LOAD);
            end
            BK_MAC: begin
                mem_re = (phase_reg < 3'd4);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Point memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // One 16-bit chunk of the division per lane: the running remainder over
    // the next chunk, divided by reciprocal multiplication.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            num[l]    = {rem_reg[l], mag_reg[l][QDW-1 -: DC]};
            qc[l]     = DC'(rprod_reg[l] >> RS);
            rem_nx[l] = RW'(num[l] - NW'(qc[l]) * NW'(DIVISOR));
            quot[l]   = neg_reg[l] ? POS_W'(-mag_reg[l]) : POS_W'(mag_reg[l]);
        end
    end

    // Complement offsets for the corner weights.
    assign sx = (OW + 1)'(SUBDIV) - (OW + 1)'(q_ox);
    assign sy = (OW + 1)'(SUBDIV) - (OW + 1)'(q_oy);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_SWEEP;
            init_done_reg <= 1'b0;
            epoch_reg     <= '0;
            sweep_reg     <= '0;
            phase_reg     <= '0;
            bit_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                BK_SWEEP: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == AW'(CELLS - 1)) begin
                        init_done_reg <= 1'b1;
                        epoch_reg     <= EW'(1);
                    end
                end
                BK_IDLE: begin
                    phase_reg <= '0;
                    sweep_reg <= '0;
                    if (pop && q_kind == CMD_CLEAR && epoch_reg != '1) begin
                        epoch_reg <= epoch_reg + 1'b1;
                    end
                end
                BK_MAC: begin
                    phase_reg <= phase_reg + 1'b1;
                end
                BK_PREP: begin
                    bit_reg <= '0;
                end
                BK_DIV: begin
                    bit_reg <= bit_reg + 1'b1;
                end
                default: begin
                    bit_reg <= bit_reg;
                end
            endcase
            if (state_reg == BK_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Interpolation datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                if (pop) begin
                    base_reg <= q_addr;
                    col_reg  <= q_col;
                    row_reg  <= q_row;
                    miss_reg <= (q_kind == CMD_MISS);
                    w_reg[0] <= WW'(sx) * WW'(sy);
                    w_reg[1] <= WW'(q_ox) * WW'(sy);
                    w_reg[2] <= WW'(sx) * WW'(q_oy);
                    w_reg[3] <= WW'(q_ox) * WW'(q_oy);
                    for (int l = 0; l < LANES; l++) begin
                        acc_reg[l] <= '0;
                    end
                end
            end
            BK_MAC: begin
                // Corner data arrives from the read register in the cycle after its read.
                if (phase_reg >= 3'd1 && phase_reg <= 3'd4) begin
                    if (rd_data_reg[3*POS_W +: EW] != epoch_reg) begin
                        miss_reg <= 1'b1;
                    end
                    for (int l = 0; l < LANES; l++) begin
                        prod_reg[l] <= SUMW'($signed(rd_data_reg[l*POS_W +: POS_W]))
                                     * SUMW'($signed({1'b0, w_reg[corner]}));
                    end
                end
                if (phase_reg >= 3'd2) begin
                    for (int l = 0; l < LANES; l++) begin
                        acc_reg[l] <= acc_reg[l] + prod_reg[l];
                    end
                end
            end
            BK_PREP: begin
                // Magnitude plus half the divisor gives round half away from zero.
                for (int l = 0; l < LANES; l++) begin
                    neg_reg[l] <= acc_reg[l][SUMW-1];
                    mag_reg[l] <= QDW'($unsigned((acc_reg[l][SUMW-1] ? SUMW'(-acc_reg[l])
                                                                   : SUMW'(acc_reg[l]))
                                                 + SUMW'(HALF_D)));
                    rem_reg[l] <= '0;
                end
            end
            BK_DIV: begin
                // Even steps form the reciprocal product, odd steps take the
                // quotient chunk and the new remainder.
                for (int l = 0; l < LANES; l++) begin
                    if (!bit_reg[0]) begin
                        rprod_reg[l] <= PW2'(num[l]) * PW2'(RMULT);
                    end else begin
                        rem_reg[l] <= rem_nx[l];
                        mag_reg[l] <= {mag_reg[l][QDW-DC-1:0], qc[l]};
                    end
                end
            end
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (state_reg == BK_OUT && out_free) begin
            m_valid_res_reg <= !miss_reg;
            m_col_reg       <= col_reg;
            m_row_reg       <= row_reg;
            for (int l = 0; l < LANES; l++) begin
                m_pos_reg[l] <= miss_reg ? '0 : quot[l];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_valid_res = m_valid_res_reg;
    assign m_echo_col  = m_col_reg;
    assign m_echo_row  = m_row_reg;
    assign m_out_px    = m_pos_reg[0];
    assign m_out_py    = m_pos_reg[1];
    assign m_out_pz    = m_pos_reg[2];

endmodule

// ===== design/masked_bilinear_grid_upsampler.sv =====
// ---------------------------------------------------------------------------
// masked_bilinear_grid_upsampler: bilinear upsampling over a masked point grid
// Loads points into a square grid, clears the presence marks, and answers
// fine-grid queries with the bilinear blend of the four cell corners.
//
//   Channel  Ports       Moves                               Handshake
//   input    s_*         opcode, load point or query coord    s_valid / s_ready
//   result   m_*         valid_res, echo, interpolated xyz     m_valid / m_ready
//
// A load or clear item is handled in the idle state as it is taken. A query
// holds the back end while it takes the command, reads the four corners from
// the point memory, forms the magnitudes, runs the chunked reciprocal
// division by SUBDIV^2 and presents the result; a query that misses the grid
// goes from the command straight to the result, and one with a missing corner
// skips the division.
// After reset a clearing pass over all GRID_SIDE^2 cells runs before items are
// accepted; every seventh clear repeats that pass when the epoch tag wraps.
// The front pipeline and command queue keep accepting, until both are full,
// while the back end works or while a result waits on m_ready.
// ---------------------------------------------------------------------------
module masked_bilinear_grid_upsampler import mbgu_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int SUBDIV    = SUBDIV_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OPCODE_W-1:0]        s_opcode,
    input  logic signed [COARSE_W-1:0] s_grid_col,
    input  logic signed [COARSE_W-1:0] s_grid_row,
    input  logic signed [POS_W-1:0]    s_load_px,
    input  logic signed [POS_W-1:0]    s_load_py,
    input  logic signed [POS_W-1:0]    s_load_pz,
    input  logic signed [FINE_W-1:0]   s_fine_col,
    input  logic signed [FINE_W-1:0]   s_fine_row,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_valid_res,
    output logic signed [FINE_W-1:0]   m_echo_col,
    output logic signed [FINE_W-1:0]   m_echo_row,
    output logic signed [POS_W-1:0]    m_out_px,
    output logic signed [POS_W-1:0]    m_out_py,
    output logic signed [POS_W-1:0]    m_out_pz
);

    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int OW = $clog2(SUBDIV + 1);
    localparam int QW = 2 + AW + 2 * OW + 2 * FINE_W + 3 * POS_W;

    logic              init_done;
    logic              f_valid, f_ready, b_valid, b_ready;
    cmd_kind_t         f_kind, b_kind;
    logic [1:0]        b_kind_bits;
    logic [AW-1:0]     f_addr, b_addr;
    logic [OW-1:0]     f_ox, f_oy, b_ox, b_oy;
    logic [FINE_W-1:0] f_col, f_row, b_col, b_row;
    logic [POS_W-1:0]  f_px, f_py, f_pz, b_px, b_py, b_pz;
    logic [QW-1:0]     f_word, b_word;

    // Front end: intake and classification.
    mbgu_front #(
        .GRID_SIDE (GRID_SIDE),
        .SUBDIV    (SUBDIV),
        .AW        (AW),
        .OW        (OW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .init_done  (init_done),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_grid_col (s_grid_col),
        .s_grid_row (s_grid_row),
        .s_load_px  (s_load_px),
        .s_load_py  (s_load_py),
        .s_load_pz  (s_load_pz),
        .s_fine_col (s_fine_col),
        .s_fine_row (s_fine_row),
        .q_valid    (f_valid),
        .q_ready    (f_ready),
        .q_kind     (f_kind),
        .q_addr     (f_addr),
        .q_ox       (f_ox),
        .q_oy       (f_oy),
        .q_col      (f_col),
        .q_row      (f_row),
        .q_px       (f_px),
        .q_py       (f_py),
        .q_pz       (f_pz)
    );

    // Command word through the queue.
    assign f_word = {f_kind, f_addr, f_ox, f_oy, f_col, f_row, f_px, f_py, f_pz};
    assign {b_kind_bits, b_addr, b_ox, b_oy, b_col, b_row, b_px, b_py, b_pz} = b_word;
    assign b_kind = cmd_kind_t'(b_kind_bits);

    mbgu_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_word),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_word)
    );

    // Back end: point store and interpolation.
    mbgu_back #(
        .GRID_SIDE (GRID_SIDE),
        .SUBDIV    (SUBDIV),
        .AW        (AW),
        .OW        (OW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .init_done   (init_done),
        .q_valid     (b_valid),
        .q_ready     (b_ready),
        .q_kind      (b_kind),
        .q_addr      (b_addr),
        .q_ox        (b_ox),
        .q_oy        (b_oy),
        .q_col       (b_col),
        .q_row       (b_row),
        .q_px        (b_px),
        .q_py        (b_py),
        .q_pz        (b_pz),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .m_echo_col  (m_echo_col),
        .m_echo_row  (m_echo_row),
        .m_out_px    (m_out_px),
        .m_out_py    (m_out_py),
        .m_out_pz    (m_out_pz)
    );

endmodule

// ===== test/masked_bilinear_grid_upsampler_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// masked_bilinear_grid_upsampler_test: self-checking bench for the upsampler
// A short table of directed items covers the grid corners, extreme positions,
// the last row and column, the reserved code and a clear. Random items, mostly
// loads and queries over a small grid window, follow. Each item is predicted,
// and each result is compared field by field in order.
// ---------------------------------------------------------------------------
module masked_bilinear_grid_upsampler_test;
    import mbgu_pkg::*;

    localparam int SIDE     = GRID_SIDE_DEF;
    localparam int SUB      = SUBDIV_DEF;
    localparam int N_RANDOM = 1350;
    localparam int STALL_LIMIT = 40000;

    // One result as the block reports it.
    typedef struct packed {
        logic                     valid_res;
        logic signed [FINE_W-1:0] echo_col;
        logic signed [FINE_W-1:0] echo_row;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
    } answer_t;

    // One input item, with an optional typed answer.
    typedef struct {
        opcode_t                    op;
        logic signed [COARSE_W-1:0] gc;
        logic signed [COARSE_W-1:0] gr;
        logic signed [POS_W-1:0]    px;
        logic signed [POS_W-1:0]    py;
        logic signed [POS_W-1:0]    pz;
        logic signed [FINE_W-1:0]   fc;
        logic signed [FINE_W-1:0]   fr;
        bit                         typed;
        answer_t                    ans;
    } item_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [OPCODE_W-1:0]        s_opcode;
    logic signed [COARSE_W-1:0] s_grid_col;
    logic signed [COARSE_W-1:0] s_grid_row;
    logic signed [POS_W-1:0]    s_load_px;
    logic signed [POS_W-1:0]    s_load_py;
    logic signed [POS_W-1:0]    s_load_pz;
    logic signed [FINE_W-1:0]   s_fine_col;
    logic signed [FINE_W-1:0]   s_fine_row;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_valid_res;
    logic signed [FINE_W-1:0]   m_echo_col;
    logic signed [FINE_W-1:0]   m_echo_row;
    logic signed [POS_W-1:0]    m_out_px;
    logic signed [POS_W-1:0]    m_out_py;
    logic signed [POS_W-1:0]    m_out_pz;

    masked_bilinear_grid_upsampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_grid_col(s_grid_col), .s_grid_row(s_grid_row),
        .s_load_px(s_load_px), .s_load_py(s_load_py), .s_load_pz(s_load_pz),
        .s_fine_col(s_fine_col), .s_fine_row(s_fine_row),
        .m_valid(m_valid), .m_ready(m_ready), .m_valid_res(m_valid_res),
        .m_echo_col(m_echo_col), .m_echo_row(m_echo_row),
        .m_out_px(m_out_px), .m_out_py(m_out_py), .m_out_pz(m_out_pz)
    );

    // Shadow copy of the grid and the answers still owed by the block.
    bit                   present [SIDE*SIDE];
    logic [POS_W-1:0]     points  [SIDE*SIDE][3];
    answer_t              pending_answers[$];
    int                   errors = 0;
    int                   send_idle = 36;
    int                   recv_idle = 68;
    int                   stall_cycles = 0;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Blend one coordinate of the four corners, rounding ties away from zero.
    function automatic logic [POS_W-1:0] blend(input int i00, input int i10, input int i01,
                                               input int i11, input int k,
                                               input int ox, input int oy);
        longint s;
        longint q;
        s = longint'($signed(points[i00][k])) * ((SUB - ox) * (SUB - oy))
          + longint'($signed(points[i10][k])) * (ox * (SUB - oy))
          + longint'($signed(points[i01][k])) * ((SUB - ox) * oy)
          + longint'($signed(points[i11][k])) * (ox * oy);
        if (s >= 0) q = (s + SUB * SUB / 2) / (SUB * SUB);
        else        q = -((-s + SUB * SUB / 2) / (SUB * SUB));
        return q[POS_W-1:0];
    endfunction

    // Apply one accepted item to the shadow grid and queue its answer.
    task automatic apply_item(input item_t it);
        int      c;
        int      r;
        int      x;
        int      y;
        int      i00;
        answer_t a;
        case (it.op)
            OP_LOAD: begin
                c = int'(it.gc) + SIDE / 2;
                r = int'(it.gr) + SIDE / 2;
                if (c >= 0 && c < SIDE && r >= 0 && r < SIDE) begin
                    points[c*SIDE+r][0] = it.px;
                    points[c*SIDE+r][1] = it.py;
                    points[c*SIDE+r][2] = it.pz;
                    present[c*SIDE+r] = 1'b1;
                end
            end
            OP_CLEAR: begin
                foreach (present[i]) present[i] = 1'b0;
            end
            OP_QUERY: begin
                a = '0;
                a.echo_col = it.fc;
                a.echo_row = it.fr;
                x = int'(it.fc) + SIDE * SUB / 2;
                y = int'(it.fr) + SIDE * SUB / 2;
                if (x >= 0 && y >= 0 && x / SUB + 1 < SIDE && y / SUB + 1 < SIDE) begin
                    i00 = (x / SUB) * SIDE + y / SUB;
                    if (present[i00] && present[i00+SIDE] && present[i00+1]
                            && present[i00+SIDE+1]) begin
                        a.valid_res = 1'b1;
                        a.px = blend(i00, i00 + SIDE, i00 + 1, i00 + SIDE + 1, 0,
                                     x % SUB, y % SUB);
                        a.py = blend(i00, i00 + SIDE, i00 + 1, i00 + SIDE + 1, 1,
                                     x % SUB, y % SUB);
                        a.pz = blend(i00, i00 + SIDE, i00 + 1, i00 + SIDE + 1, 2,
                                     x % SUB, y % SUB);
                    end
                end
                pending_answers.push_back(it.typed ? it.ans : a);
            end
            default: ;
        endcase
    endtask

    // Present one item and hold it until taken, then maybe idle a while.
    task automatic send_item(input item_t it);
        int gap;
        s_valid    <= 1'b1;
        s_opcode   <= it.op;
        s_grid_col <= it.gc;
        s_grid_row <= it.gr;
        s_load_px  <= it.px;
        s_load_py  <= it.py;
        s_load_pz  <= it.pz;
        s_fine_col <= it.fc;
        s_fine_row <= it.fr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_item(it);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [POS_W-1:0] random_position();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic item_t make_item(input opcode_t op, input int gc, input int gr,
                                        input logic [POS_W-1:0] px,
                                        input logic [POS_W-1:0] py,
                                        input logic [POS_W-1:0] pz,
                                        input int fc, input int fr,
                                        input bit typed, input bit v);
        item_t it;
        it.op = op;
        it.gc = gc[COARSE_W-1:0];
        it.gr = gr[COARSE_W-1:0];
        it.px = px;
        it.py = py;
        it.pz = pz;
        it.fc = fc[FINE_W-1:0];
        it.fr = fr[FINE_W-1:0];
        it.typed = typed;
        it.ans = '0;
        it.ans.valid_res = v;
        it.ans.echo_col = fc[FINE_W-1:0];
        it.ans.echo_row = fr[FINE_W-1:0];
        return it;
    endfunction

    // Random item, mostly loads and queries inside a small window of the grid.
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    base_c;
        int    base_r;
        pick = $urandom_range(99);
        base_c = $urandom_range(0, 5) - 3;
        base_r = $urandom_range(0, 5) - 3;
        it = make_item(OP_LOAD, base_c, base_r, random_position(), random_position(),
                       random_position(), $urandom_range(255) - 128,
                       $urandom_range(255) - 128, 1'b0, 1'b0);
        if (pick < 40) begin
            it.op = OP_LOAD;
        end else if (pick < 88) begin
            it.op = OP_QUERY;
            it.fc = FINE_W'(base_c * SUB + int'($urandom_range(SUB - 1)));
            it.fr = FINE_W'(base_r * SUB + int'($urandom_range(SUB - 1)));
        end else if (pick < 93) begin
            it.op = OP_LOAD;
            it.gc = COARSE_W'($urandom());
            it.gr = COARSE_W'($urandom());
        end else if (pick < 97) begin
            it.op = OP_QUERY;
        end else if (pick < 99) begin
            it.op = OP_RSVD;
        end else begin
            it.op = OP_CLEAR;
        end
        return it;
    endfunction

    // Receiver: check each taken result, then choose the next ready level.
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (m_valid_res !== e.valid_res) begin
                    $error("valid_res: expected %0d, got %0d", e.valid_res, m_valid_res);
                    errors++;
                end
                if (m_echo_col !== e.echo_col) begin
                    $error("echo_col: expected %0d, got %0d", e.echo_col, m_echo_col);
                    errors++;
                end
                if (m_echo_row !== e.echo_row) begin
                    $error("echo_row: expected %0d, got %0d", e.echo_row, m_echo_row);
                    errors++;
                end
                if (m_out_px !== e.px) begin
                    $error("out_px: expected %h, got %h", e.px, m_out_px);
                    errors++;
                end
                if (m_out_py !== e.py) begin
                    $error("out_py: expected %h, got %h", e.py, m_out_py);
                    errors++;
                end
                if (m_out_pz !== e.pz) begin
                    $error("out_pz: expected %h, got %h", e.pz, m_out_pz);
                    errors++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("masked_bilinear_grid_upsampler_test: done, errors");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        item_t directed[$];
        s_valid    <= 1'b0;
        m_ready    <= 1'b0;
        s_opcode   <= OP_LOAD;
        s_grid_col <= '0;
        s_grid_row <= '0;
        s_load_px  <= '0;
        s_load_py  <= '0;
        s_load_pz  <= '0;
        s_fine_col <= '0;
        s_fine_row <= '0;
        aresetn    <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn    <= 1'b1;

        // Directed table: corners of the grid, extreme positions and edge cells.
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, -128, -128, 1, 0));
        directed.push_back(make_item(OP_LOAD, -32, -32, 32'h8000_0000, 32'h7fff_ffff,
                                     32'h0000_0000, 0, 0, 0, 0));
        directed.push_back(make_item(OP_LOAD, -31, -32, 32'h7fff_ffff, 32'h8000_0000,
                                     32'hffff_ffff, 0, 0, 0, 0));
        directed.push_back(make_item(OP_LOAD, -32, -31, 32'h8000_0000, 32'h8000_0000,
                                     32'h0000_0001, 0, 0, 0, 0));
        directed.push_back(make_item(OP_LOAD, -31, -31, 32'h7fff_ffff, 32'h7fff_ffff,
                                     32'hffff_fff8, 0, 0, 0, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, -128, -128, 0, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, -125, -126, 0, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, -126, -125, 0, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, 127, 127, 1, 0));
        directed.push_back(make_item(OP_RSVD, -1, -1, 32'hffff_ffff, 32'hffff_ffff,
                                     32'hffff_ffff, -1, -1, 0, 0));
        directed.push_back(make_item(OP_LOAD, 31, 31, 32'h7fff_ffff, 32'h8000_0000,
                                     32'h7fff_ffff, 0, 0, 0, 0));
        directed.push_back(make_item(OP_LOAD, 30, 30, 32'h1234_5678, 32'h8765_4321,
                                     32'h0000_0100, 0, 0, 0, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, 124, 124, 1, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, 121, 121, 1, 0));
        directed.push_back(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, -128, -128, 1, 0));
        directed.push_back(make_item(OP_LOAD, -32, -32, 32'h0000_0100, 32'h0000_0200,
                                     32'h0000_0300, 0, 0, 0, 0));
        directed.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, -127, -127, 1, 0));
        foreach (directed[i]) send_item(directed[i]);

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 36 : (phase == 1) ? 68 : 0;
            recv_idle = (phase == 0) ? 68 : (phase == 1) ? 36 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) send_item(random_item());
        end
        s_valid <= 1'b0;

        // Drain the outstanding answers, then let the back end settle.
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("masked_bilinear_grid_upsampler_test: done, clean");
        end else begin
            $display("masked_bilinear_grid_upsampler_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mbgu_pkg.sv
design/mbgu_fifo.sv
design/mbgu_front.sv
design/mbgu_back.sv
design/masked_bilinear_grid_upsampler.sv
test/masked_bilinear_grid_upsampler_test.sv
